/* rtl/core/pgi_pkg.sv */
package pgi_pkg;

   // command codes
   localparam logic [1:0] CMD_WRITE    = 2'd0;
   localparam logic [1:0] CMD_INTERACT = 2'd1;
   localparam logic [1:0] CMD_UPDATE   = 2'd2;
   localparam logic [1:0] CMD_READ     = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_GRAV_DIVISOR = 2'd0;
   localparam logic [1:0] CSR_TIME_STEP    = 2'd1;
   localparam logic [1:0] CSR_MIN_DISTANCE = 2'd2;

   localparam logic [31:0] GRAV_RESET = 32'd65536;
   localparam logic [31:0] STEP_RESET = 32'd65536;
   localparam logic [31:0] DIST_RESET = 32'd262144;

   // step counts, loaded as count minus one
   localparam logic [6:0] SQRT_LAST  = 7'd33;
   localparam logic [6:0] DIV64_LAST = 7'd63;
   localparam logic [6:0] DIV80_LAST = 7'd79;
   localparam logic [6:0] DIV97_LAST = 7'd96;

   localparam logic [46:0] COMP_MAX  = 47'h7FFF_FFFF_FFFF;
   localparam logic [33:0] ACCEL_MAX = 34'h2_0000_0000;

   typedef enum logic [5:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_I_RDA,
      ST_I_RDB,
      ST_I_LDB,
      ST_I_SQ1,
      ST_I_SQ2,
      ST_I_SQ3,
      ST_SQRT,
      ST_I_DCHK,
      ST_I_QDIV,
      ST_DIV,
      ST_I_F1,
      ST_I_F2,
      ST_I_FX0,
      ST_I_FX1,
      ST_I_FX2,
      ST_I_FY0,
      ST_I_FY1,
      ST_I_FY2,
      ST_I_ACA,
      ST_I_ACB,
      ST_I_ACW,
      ST_U_RD,
      ST_U_LD,
      ST_U_ACC,
      ST_U_VEL,
      ST_U_MUL,
      ST_U_POS,
      ST_U_WR,
      ST_FIN_RD,
      ST_FIN_LD
   } state_type;

endpackage

/* rtl/core/pairwise_gravity_integrator.sv */
// channel   direction  beat on               payload
// req_      in         req_valid & ready     command, index_a/b, pos, vel, body_mass
// rsp_      out        rsp_valid & ready     pos, vel of index_a, pair_applied, saturated
// csr_      in         csr_valid (ready=1)   csr_index, csr_wdata
//
// one command at a time through a shared multiplier and a shared
// divide / square-root step unit, one quotient or root bit per cycle.
// an interact runs 34 root steps and divisions of 64, 80, 80, 97 and 97 steps.
// after reset a pass that writes every entry of the force store clears it before
// the first command is taken; register writes are taken throughout.
// a finished result sits in the output register while the next command runs.
module pairwise_gravity_integrator #(
   parameter int MAX_BODIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_index_a,
   input  logic [7:0]  req_index_b,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic [31:0] req_body_mass,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_out_pos_x,
   output logic signed [31:0] rsp_out_pos_y,
   output logic signed [31:0] rsp_out_vel_x,
   output logic signed [31:0] rsp_out_vel_y,
   output logic        rsp_pair_applied,
   output logic        rsp_saturated,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import pgi_pkg::*;

   localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
   localparam logic [16:0] MaxBodies = 17'(MAX_BODIES);
   localparam logic [AW-1:0] LastAddr = AW'(MAX_BODIES - 1);

   // stores
   logic [159:0] body_mem [MAX_BODIES];
   logic [95:0]  force_mem [MAX_BODIES];

   state_type state_ff, state_in, ret_ff, ret_in;

   logic [31:0] grav_ff, dt_ff, mind_ff;

   logic [1:0]  cmd_ff, cmd_in;
   logic [AW-1:0] ia_ff, ia_in, ib_ff, ib_in, clr_ff, clr_in;
   logic        va_ff, va_in;
   logic signed [31:0] px_ff, px_in, py_ff, py_in, vx_ff, vx_in, vy_ff, vy_in;
   logic [31:0] ma_ff, ma_in, mb_ff, mb_in;
   logic signed [47:0] fx_ff, fx_in, fy_ff, fy_in;
   logic signed [32:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [33:0] d_ff, d_in, dvs_ff, dvs_in;
   logic [63:0] fq_ff, fq_in, quo_ff, quo_in;
   logic [66:0] wide_ff, wide_in;
   logic [65:0] prod_ff;
   logic [97:0] num_ff, num_in;
   logic [36:0] rem_ff, rem_in;
   logic        ovf_ff, ovf_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [46:0] cx_ff, cx_in, cy_ff, cy_in;
   logic        axis_ff, axis_in, sat_ff, sat_in, applied_ff, applied_in;
   logic [159:0] body_rd_ff;
   logic [95:0]  force_rd_ff;
   logic        rsp_valid_ff, rsp_valid_in, rsp_app_ff, rsp_app_in, rsp_sat_ff, rsp_sat_in;
   logic signed [31:0] rsp_px_ff, rsp_px_in, rsp_py_ff, rsp_py_in;
   logic signed [31:0] rsp_vx_ff, rsp_vx_in, rsp_vy_ff, rsp_vy_in;

   // memory and multiplier control
   logic          body_re, body_we, force_re, force_we;
   logic [AW-1:0] body_raddr, force_raddr, body_waddr, force_waddr;
   logic [159:0]  body_wdata;
   logic [95:0]   force_wdata;
   logic [32:0]   mul_a, mul_b;

   // shared helpers
   logic        req_beat, va_req, vb_req, fin_load;
   logic [16:0] idx_a17, idx_b17;
   logic [63:0] div_res;
   logic [34:0] div_t;
   logic        div_ge;
   logic [36:0] sq_t, sq_trial;
   logic        sq_ge;
   logic [32:0] ax_abs, ay_abs, v_abs;
   logic [96:0] p97;
   logic [66:0] d2_sum;
   logic [46:0] comp_clip;
   logic signed [47:0] sx, sy, cur_f;
   logic signed [31:0] cur_v, cur_p;
   logic [47:0] f_abs;
   logic [33:0] accel;
   logic signed [34:0] v35;
   logic signed [31:0] v_new, p_new;
   logic signed [49:0] p50;
   logic [47:0] step48;
   logic signed [47:0] fa_x, fa_y, fb_x, fb_y;

   function automatic logic signed [47:0] sat48(input logic signed [48:0] s);
      logic signed [47:0] r;
      if (s[48] != s[47]) begin
         r = s[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
      end else begin
         r = s[47:0];
      end
      return r;
   endfunction

   assign idx_a17  = {9'b0, req_index_a};
   assign idx_b17  = {9'b0, req_index_b};
   assign va_req   = idx_a17 < MaxBodies;
   assign vb_req   = idx_b17 < MaxBodies;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_beat = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign fin_load = (state_ff == ST_FIN_LD) && (!rsp_valid_ff || rsp_ready);

   assign div_res = ovf_ff ? {64{1'b1}} : quo_ff;
   assign div_t   = {rem_ff[33:0], num_ff[97]};
   assign div_ge  = div_t >= {1'b0, dvs_ff};
   assign sq_t    = {rem_ff[34:0], num_ff[97:96]};
   assign sq_trial = {1'b0, quo_ff[33:0], 2'b01};
   assign sq_ge   = sq_t >= sq_trial;

   assign ax_abs = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
   assign ay_abs = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
   assign d2_sum = wide_ff + {1'b0, prod_ff};
   assign p97    = {prod_ff[64:0], 32'b0} + {32'b0, wide_ff[64:0]};
   assign comp_clip = (div_res >= {17'b0, COMP_MAX}) ? COMP_MAX : div_res[46:0];
   assign sx = dx_ff[32] ? -$signed({1'b0, cx_ff}) : $signed({1'b0, cx_ff});
   assign sy = dy_ff[32] ? -$signed({1'b0, cy_ff}) : $signed({1'b0, cy_ff});
   assign fa_x = force_rd_ff[95:48];
   assign fa_y = force_rd_ff[47:0];
   assign fb_x = sat48({fa_x[47], fa_x} - {sx[47], sx});
   assign fb_y = sat48({fa_y[47], fa_y} - {sy[47], sy});

   // per-axis update path
   assign cur_f  = axis_ff ? fy_ff : fx_ff;
   assign cur_v  = axis_ff ? vy_ff : vx_ff;
   assign cur_p  = axis_ff ? py_ff : px_ff;
   assign f_abs  = cur_f[47] ? 48'(-cur_f) : 48'(cur_f);
   assign accel  = (ma_ff == 32'b0) ? 34'b0
                 : ((div_res > {30'b0, ACCEL_MAX}) ? ACCEL_MAX : div_res[33:0]);
   assign v35    = {{3{cur_v[31]}}, cur_v}
                 + (cur_f[47] ? -$signed({1'b0, accel}) : $signed({1'b0, accel}));
   assign v_new  = (v35[34:31] == 4'b0000 || v35[34:31] == 4'b1111) ? v35[31:0]
                 : (v35[34] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}});
   assign v_abs  = cur_v[31] ? -{1'b1, cur_v} : {1'b0, cur_v};
   assign step48 = prod_ff[63:16];
   assign p50    = {{18{cur_p[31]}}, cur_p}
                 + (cur_v[31] ? -$signed({2'b0, step48}) : $signed({2'b0, step48}));
   assign p_new  = (p50[49:31] == {19{1'b0}} || p50[49:31] == {19{1'b1}}) ? p50[31:0]
                 : (p50[49] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (clr_ff == LastAddr) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_beat) begin
               if (req_command == CMD_WRITE && va_req) begin
                  state_in = ST_WRITE;
               end else if (req_command == CMD_INTERACT && va_req && vb_req) begin
                  state_in = ST_I_RDA;
               end else if (req_command == CMD_UPDATE && va_req) begin
                  state_in = ST_U_RD;
               end else begin
                  state_in = ST_FIN_RD;
               end
            end
         end
         ST_WRITE:  state_in = ST_FIN_RD;
         ST_I_RDA:  state_in = ST_I_RDB;
         ST_I_RDB:  state_in = ST_I_LDB;
         ST_I_LDB:  state_in = ST_I_SQ1;
         ST_I_SQ1:  state_in = ST_I_SQ2;
         ST_I_SQ2:  state_in = ST_I_SQ3;
         ST_I_SQ3:  state_in = ST_SQRT;
         ST_SQRT:   if (cnt_ff == 7'd0) state_in = ret_ff;
         ST_DIV:    if (cnt_ff == 7'd0) state_in = ret_ff;
         ST_I_DCHK: state_in = (quo_ff[33:0] > {2'b0, mind_ff}) ? ST_I_QDIV : ST_FIN_RD;
         ST_I_QDIV: state_in = ST_DIV;
         ST_I_F1:   state_in = ST_DIV;
         ST_I_F2:   state_in = ST_DIV;
         ST_I_FX0:  state_in = ST_I_FX1;
         ST_I_FX1:  state_in = ST_I_FX2;
         ST_I_FX2:  state_in = ST_DIV;
         ST_I_FY0:  state_in = ST_I_FY1;
         ST_I_FY1:  state_in = ST_I_FY2;
         ST_I_FY2:  state_in = ST_DIV;
         ST_I_ACA:  state_in = ST_I_ACB;
         ST_I_ACB:  state_in = ST_I_ACW;
         ST_I_ACW:  state_in = ST_FIN_RD;
         ST_U_RD:   state_in = ST_U_LD;
         ST_U_LD:   state_in = ST_U_ACC;
         ST_U_ACC:  state_in = (ma_ff == 32'b0) ? ST_U_VEL : ST_DIV;
         ST_U_VEL:  state_in = ST_U_MUL;
         ST_U_MUL:  state_in = ST_U_POS;
         ST_U_POS:  state_in = axis_ff ? ST_U_WR : ST_U_ACC;
         ST_U_WR:   state_in = ST_FIN_RD;
         ST_FIN_RD: state_in = ST_FIN_LD;
         ST_FIN_LD: if (fin_load) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // memory ports and multiplier operands
   always_comb begin
      body_re     = 1'b0;
      body_raddr  = ia_ff;
      body_we     = 1'b0;
      body_waddr  = ia_ff;
      body_wdata  = {px_ff, py_ff, vx_ff, vy_ff, ma_ff};
      force_re    = 1'b0;
      force_raddr = ia_ff;
      force_we    = 1'b0;
      force_waddr = ia_ff;
      force_wdata = 96'b0;
      mul_a       = ax_abs;
      mul_b       = ax_abs;
      case (state_ff)
         ST_CLEAR: begin
            force_we    = 1'b1;
            force_waddr = clr_ff;
         end
         ST_WRITE, ST_U_WR: begin
            body_we  = 1'b1;
            force_we = 1'b1;
         end
         ST_I_RDA, ST_FIN_RD: body_re = 1'b1;
         ST_I_RDB: begin
            body_re    = 1'b1;
            body_raddr = ib_ff;
         end
         ST_I_SQ2: begin
            mul_a = ay_abs;
            mul_b = ay_abs;
         end
         ST_I_DCHK: begin
            mul_a = {1'b0, ma_ff};
            mul_b = {1'b0, mb_ff};
         end
         ST_I_FX0: mul_a = {1'b0, div_res[31:0]};
         ST_I_FX1: mul_a = {1'b0, fq_ff[63:32]};
         ST_I_FY0: begin
            mul_a = {1'b0, fq_ff[31:0]};
            mul_b = ay_abs;
         end
         ST_I_FY1: begin
            mul_a = {1'b0, fq_ff[63:32]};
            mul_b = ay_abs;
         end
         ST_I_ACA: force_re = 1'b1;
         ST_I_ACB: begin
            force_we    = 1'b1;
            force_wdata = {sat48({fa_x[47], fa_x} + {sx[47], sx}),
                           sat48({fa_y[47], fa_y} + {sy[47], sy})};
            force_re    = 1'b1;
            force_raddr = ib_ff;
         end
         ST_I_ACW: begin
            force_we    = 1'b1;
            force_waddr = ib_ff;
            force_wdata = {fb_x, fb_y};
         end
         ST_U_RD: begin
            body_re  = 1'b1;
            force_re = 1'b1;
         end
         ST_U_MUL: begin
            mul_a = v_abs;
            mul_b = {1'b0, dt_ff};
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      ret_in     = ret_ff;
      cmd_in     = cmd_ff;
      ia_in      = ia_ff;
      ib_in      = ib_ff;
      va_in      = va_ff;
      clr_in     = clr_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      vx_in      = vx_ff;
      vy_in      = vy_ff;
      ma_in      = ma_ff;
      mb_in      = mb_ff;
      fx_in      = fx_ff;
      fy_in      = fy_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      d_in       = d_ff;
      dvs_in     = dvs_ff;
      fq_in      = fq_ff;
      wide_in    = wide_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      ovf_in     = ovf_ff;
      cnt_in     = cnt_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      axis_in    = axis_ff;
      sat_in     = sat_ff;
      applied_in = applied_ff;
      rsp_px_in  = rsp_px_ff;
      rsp_py_in  = rsp_py_ff;
      rsp_vx_in  = rsp_vx_ff;
      rsp_vy_in  = rsp_vy_ff;
      rsp_app_in = rsp_app_ff;
      rsp_sat_in = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_CLEAR: clr_in = clr_ff + AW'(1);
         ST_IDLE: begin
            if (req_beat) begin
               cmd_in     = req_command;
               ia_in      = idx_a17[AW-1:0];
               ib_in      = idx_b17[AW-1:0];
               va_in      = va_req;
               px_in      = req_pos_x;
               py_in      = req_pos_y;
               vx_in      = req_vel_x;
               vy_in      = req_vel_y;
               ma_in      = req_body_mass;
               sat_in     = 1'b0;
               applied_in = 1'b0;
            end
         end
         ST_I_RDB: begin
            px_in = body_rd_ff[159:128];
            py_in = body_rd_ff[127:96];
            ma_in = body_rd_ff[31:0];
         end
         ST_I_LDB: begin
            dx_in = {body_rd_ff[159], body_rd_ff[159:128]} - {px_ff[31], px_ff};
            dy_in = {body_rd_ff[127], body_rd_ff[127:96]} - {py_ff[31], py_ff};
            mb_in = body_rd_ff[31:0];
         end
         ST_I_SQ2: wide_in = {1'b0, prod_ff};
         ST_I_SQ3: begin
            num_in = {1'b0, d2_sum, 30'b0};
            rem_in = 37'b0;
            quo_in = 64'b0;
            cnt_in = SQRT_LAST;
            ret_in = ST_I_DCHK;
         end
         ST_SQRT: begin
            rem_in = sq_ge ? sq_t - sq_trial : sq_t;
            quo_in = {quo_ff[62:0], sq_ge};
            num_in = {num_ff[95:0], 2'b00};
            cnt_in = cnt_ff - 7'd1;
         end
         ST_DIV: begin
            rem_in = {3'b0, 34'(div_ge ? div_t - {1'b0, dvs_ff} : div_t)};
            quo_in = {quo_ff[62:0], div_ge};
            ovf_in = ovf_ff | quo_ff[63];
            num_in = {num_ff[96:0], 1'b0};
            cnt_in = cnt_ff - 7'd1;
         end
         ST_I_DCHK: d_in = quo_ff[33:0];
         ST_I_QDIV: begin
            num_in = {prod_ff[63:0], 34'b0};
            dvs_in = {2'b0, (grav_ff == 32'b0) ? 32'd1 : grav_ff};
            cnt_in = DIV64_LAST;
            rem_in = 37'b0;
            quo_in = 64'b0;
            ovf_in = 1'b0;
            ret_in = ST_I_F1;
         end
         ST_I_F1, ST_I_F2: begin
            num_in = {div_res, 34'b0};
            dvs_in = d_ff;
            cnt_in = DIV80_LAST;
            rem_in = 37'b0;
            quo_in = 64'b0;
            ovf_in = 1'b0;
            ret_in = (state_ff == ST_I_F1) ? ST_I_F2 : ST_I_FX0;
         end
         ST_I_FX0: fq_in = div_res;
         ST_I_FX1, ST_I_FY1: wide_in = {2'b0, prod_ff[64:0]};
         ST_I_FX2, ST_I_FY2: begin
            num_in = {p97, 1'b0};
            dvs_in = d_ff;
            cnt_in = DIV97_LAST;
            rem_in = 37'b0;
            quo_in = 64'b0;
            ovf_in = 1'b0;
            ret_in = (state_ff == ST_I_FX2) ? ST_I_FY0 : ST_I_ACA;
         end
         ST_I_FY0: cx_in = comp_clip;
         ST_I_ACA: cy_in = comp_clip;
         ST_I_ACW: applied_in = 1'b1;
         ST_U_LD: begin
            px_in   = body_rd_ff[159:128];
            py_in   = body_rd_ff[127:96];
            vx_in   = body_rd_ff[95:64];
            vy_in   = body_rd_ff[63:32];
            ma_in   = body_rd_ff[31:0];
            fx_in   = force_rd_ff[95:48];
            fy_in   = force_rd_ff[47:0];
            axis_in = 1'b0;
         end
         ST_U_ACC: begin
            num_in = {f_abs, 16'b0, 34'b0};
            dvs_in = {2'b0, ma_ff};
            cnt_in = DIV64_LAST;
            rem_in = 37'b0;
            quo_in = 64'b0;
            ovf_in = 1'b0;
            ret_in = ST_U_VEL;
         end
         ST_U_VEL: begin
            if (axis_ff) begin
               vy_in = v_new;
            end else begin
               vx_in = v_new;
            end
            if (v_new != v35[31:0] || v35[34:31] == 4'b0001 || v35[34:31] == 4'b1110) begin
               sat_in = 1'b1;
            end
         end
         ST_U_POS: begin
            if (axis_ff) begin
               py_in = p_new;
            end else begin
               px_in = p_new;
            end
            if (!(p50[49:31] == {19{1'b0}} || p50[49:31] == {19{1'b1}})) begin
               sat_in = 1'b1;
            end
            axis_in = 1'b1;
         end
         ST_FIN_LD: begin
            if (fin_load) begin
               rsp_valid_in = 1'b1;
               rsp_px_in    = va_ff ? body_rd_ff[159:128] : 32'b0;
               rsp_py_in    = va_ff ? body_rd_ff[127:96] : 32'b0;
               rsp_vx_in    = va_ff ? body_rd_ff[95:64] : 32'b0;
               rsp_vy_in    = va_ff ? body_rd_ff[63:32] : 32'b0;
               rsp_app_in   = applied_ff;
               rsp_sat_in   = sat_ff;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         grav_ff      <= GRAV_RESET;
         dt_ff        <= STEP_RESET;
         mind_ff      <= DIST_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_GRAV_DIVISOR: grav_ff <= csr_wdata;
               CSR_TIME_STEP:    dt_ff   <= csr_wdata;
               CSR_MIN_DISTANCE: mind_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ret_ff     <= ret_in;
      cmd_ff     <= cmd_in;
      ia_ff      <= ia_in;
      ib_ff      <= ib_in;
      va_ff      <= va_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      vx_ff      <= vx_in;
      vy_ff      <= vy_in;
      ma_ff      <= ma_in;
      mb_ff      <= mb_in;
      fx_ff      <= fx_in;
      fy_ff      <= fy_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      d_ff       <= d_in;
      dvs_ff     <= dvs_in;
      fq_ff      <= fq_in;
      wide_ff    <= wide_in;
      prod_ff    <= mul_a * mul_b;
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      ovf_ff     <= ovf_in;
      cnt_ff     <= cnt_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      axis_ff    <= axis_in;
      sat_ff     <= sat_in;
      applied_ff <= applied_in;
      rsp_px_ff  <= rsp_px_in;
      rsp_py_ff  <= rsp_py_in;
      rsp_vx_ff  <= rsp_vx_in;
      rsp_vy_ff  <= rsp_vy_in;
      rsp_app_ff <= rsp_app_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   // body and force stores
   always_ff @(posedge clock) begin
      if (body_we) begin
         body_mem[body_waddr] <= body_wdata;
      end
      if (body_re) begin
         body_rd_ff <= body_mem[body_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (force_we) begin
         force_mem[force_waddr] <= force_wdata;
      end
      if (force_re) begin
         force_rd_ff <= force_mem[force_raddr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_pos_x    = rsp_px_ff;
   assign rsp_out_pos_y    = rsp_py_ff;
   assign rsp_out_vel_x    = rsp_vx_ff;
   assign rsp_out_vel_y    = rsp_vy_ff;
   assign rsp_pair_applied = rsp_app_ff;
   assign rsp_saturated    = rsp_sat_ff;

endmodule

/* tb/pairwise_gravity_integrator_tb.sv */
module pairwise_gravity_integrator_tb;
   import pgi_pkg::*;

   localparam int  IDLE_LIMIT = 6000;
   localparam int  PHASE_ITEMS = 200;
   localparam longint FORCE_LIM = 64'sh7FFF_FFFF_FFFF;
   localparam longint I32_MAX = 64'sh7FFF_FFFF;
   localparam longint I32_MIN = -64'sh8000_0000;

   typedef struct {
      logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
      logic               applied, sat;
   } body_state_t;

   class gravity_scoreboard;
      longint             px[256], py[256], vx[256], vy[256], fx[256], fy[256];
      logic [63:0]        mass[256];
      logic [63:0]        grav, dt, dmin;
      body_state_t        awaited[$];
      bit                 failed;

      function new();
         grav = GRAV_RESET;
         dt   = STEP_RESET;
         dmin = DIST_RESET;
         foreach (fx[i]) begin
            fx[i] = 0;
            fy[i] = 0;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            CSR_GRAV_DIVISOR: grav = val;
            CSR_TIME_STEP:    dt   = val;
            CSR_MIN_DISTANCE: dmin = val;
            default: ;
         endcase
      endfunction

      // quotient saturating at 2^64-1
      function logic [63:0] sat_div(logic [127:0] num, logic [63:0] den);
         logic [127:0] q;
         q = num / {64'd0, den};
         return (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
      endfunction

      function logic [63:0] root(logic [127:0] sq);
         logic [63:0]  r, c;
         r = 0;
         for (int b = 33; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= sq) r = c;
         end
         return r;
      endfunction

      function longint along(logic [63:0] f, longint delta, logic [63:0] d);
         logic [63:0] mag, c;
         mag = delta < 0 ? -delta : delta;
         c = sat_div({64'd0, f} * {64'd0, mag}, d);
         if (c > FORCE_LIM) c = FORCE_LIM;
         return delta < 0 ? -longint'(c) : longint'(c);
      endfunction

      function longint acc_add(longint acc, longint delta);
         longint s;
         s = acc + delta;
         if (s > FORCE_LIM) s = FORCE_LIM;
         if (s < -FORCE_LIM - 1) s = -FORCE_LIM - 1;
         return s;
      endfunction

      function bit pull(int a, int b);
         longint       dx, dy, cx, cy;
         logic [63:0]  ax, ay, d, g, q, f1, f;
         logic [127:0] sq;
         dx = px[b] - px[a];
         dy = py[b] - py[a];
         ax = dx < 0 ? -dx : dx;
         ay = dy < 0 ? -dy : dy;
         sq = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay};
         d = root(sq);
         if (d <= dmin) return 0;
         g = (grav == 0) ? 64'd1 : grav;
         q = (mass[a] * mass[b]) / g;
         f1 = sat_div({64'd0, q} << 16, d);
         f  = sat_div({64'd0, f1} << 16, d);
         cx = along(f, dx, d);
         cy = along(f, dy, d);
         fx[a] = acc_add(fx[a], cx);
         fy[a] = acc_add(fy[a], cy);
         fx[b] = acc_add(fx[b], -cx);
         fy[b] = acc_add(fy[b], -cy);
         return 1;
      endfunction

      function longint clip32(longint v, inout bit sat);
         if (v > I32_MAX) begin
            sat = 1;
            return I32_MAX;
         end
         if (v < I32_MIN) begin
            sat = 1;
            return I32_MIN;
         end
         return v;
      endfunction

      function void advance(inout longint p, inout longint v, input longint f,
                            input logic [63:0] m, inout bit sat);
         logic [63:0] num, acc, mv;
         if (m != 0) begin
            num = (f < 0 ? -f : f);
            num = num << 16;
            acc = num / m;
            if (acc > 64'h2_0000_0000) acc = 64'h2_0000_0000;
            v = f < 0 ? v - longint'(acc) : v + longint'(acc);
         end
         v = clip32(v, sat);
         mv = (v < 0 ? -v : v);
         mv = (mv * dt) >> 16;
         p = clip32(v < 0 ? p - longint'(mv) : p + longint'(mv), sat);
      endfunction

      function void note(logic [1:0] cmd, int a, int b, logic [31:0] ipx, ipy, ivx, ivy,
                         logic [31:0] im);
         body_state_t e;
         bit          sat;
         e.applied = 0;
         sat = 0;
         case (cmd)
            CMD_WRITE: begin
               px[a] = longint'($signed(ipx));
               py[a] = longint'($signed(ipy));
               vx[a] = longint'($signed(ivx));
               vy[a] = longint'($signed(ivy));
               mass[a] = im;
               fx[a] = 0;
               fy[a] = 0;
            end
            CMD_INTERACT: e.applied = pull(a, b);
            CMD_UPDATE: begin
               advance(px[a], vx[a], fx[a], mass[a], sat);
               advance(py[a], vy[a], fy[a], mass[a], sat);
               fx[a] = 0;
               fy[a] = 0;
            end
            default: ;
         endcase
         e.sat = sat;
         e.pos_x = px[a][31:0];
         e.pos_y = py[a][31:0];
         e.vel_x = vx[a][31:0];
         e.vel_y = vy[a][31:0];
         awaited.push_back(e);
      endfunction

      function void check(body_state_t got);
         body_state_t e;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected result beat pos %0d,%0d", $time, got.pos_x, got.pos_y);
            failed = 1;
            return;
         end
         e = awaited.pop_front();
         if (got.pos_x !== e.pos_x) begin
            $display("%0t: pos_x expected %0d actual %0d", $time, e.pos_x, got.pos_x);
            failed = 1;
         end
         if (got.pos_y !== e.pos_y) begin
            $display("%0t: pos_y expected %0d actual %0d", $time, e.pos_y, got.pos_y);
            failed = 1;
         end
         if (got.vel_x !== e.vel_x) begin
            $display("%0t: vel_x expected %0d actual %0d", $time, e.vel_x, got.vel_x);
            failed = 1;
         end
         if (got.vel_y !== e.vel_y) begin
            $display("%0t: vel_y expected %0d actual %0d", $time, e.vel_y, got.vel_y);
            failed = 1;
         end
         if (got.applied !== e.applied) begin
            $display("%0t: pair_applied expected %0b actual %0b", $time, e.applied,
                     got.applied);
            failed = 1;
         end
         if (got.sat !== e.sat) begin
            $display("%0t: saturated expected %0b actual %0b", $time, e.sat, got.sat);
            failed = 1;
         end
      endfunction
   endclass

   logic        clock, reset;
   logic        req_valid, req_ready;
   logic [1:0]  req_command;
   logic [7:0]  req_index_a, req_index_b;
   logic signed [31:0] req_pos_x, req_pos_y, req_vel_x, req_vel_y;
   logic [31:0] req_body_mass;
   logic        rsp_valid, rsp_ready;
   logic signed [31:0] rsp_out_pos_x, rsp_out_pos_y, rsp_out_vel_x, rsp_out_vel_y;
   logic        rsp_pair_applied, rsp_saturated;
   logic        csr_valid, csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   gravity_scoreboard sb = new();
   bit [255:0] loaded;
   bit         long_hold;
   int         idle_cycles;
   int         calm_items;

   pairwise_gravity_integrator dut (.*);

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      body_state_t got;
      if (!reset) begin
         idle_cycles = idle_cycles + 1;
         if (csr_valid && csr_ready) begin
            sb.set_reg(csr_index, csr_wdata);
            idle_cycles = 0;
         end
         if (req_valid && req_ready) begin
            sb.note(req_command, req_index_a, req_index_b, req_pos_x, req_pos_y, req_vel_x,
                    req_vel_y, req_body_mass);
            idle_cycles = 0;
         end
         if (rsp_valid && rsp_ready) begin
            got.pos_x = rsp_out_pos_x;
            got.pos_y = rsp_out_pos_y;
            got.vel_x = rsp_out_vel_x;
            got.vel_y = rsp_out_vel_y;
            got.applied = rsp_pair_applied;
            got.sat = rsp_saturated;
            sb.check(got);
            idle_cycles = 0;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // result side: random stalls, quiet stretches and one long hold-off
   initial begin
      int stall, calm;
      rsp_ready = 1'b0;
      stall = 0;
      calm = 0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_ready = 1'b0;
            repeat (400) @(negedge clock);
            long_hold = 0;
         end else if (stall > 0) begin
            rsp_ready = 1'b0;
            stall--;
         end else begin
            rsp_ready = 1'b1;
            if (calm > 0) calm--;
            else if ($urandom_range(0, 199) == 0) calm = 80;
            else if ($urandom_range(0, 3) == 0) stall = gap_len();
         end
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send(logic [1:0] cmd, logic [7:0] a, logic [7:0] b, logic [31:0] ipx,
                       logic [31:0] ipy, logic [31:0] ivx, logic [31:0] ivy,
                       logic [31:0] im);
      int g;
      req_command = cmd;
      req_index_a = a;
      req_index_b = b;
      req_pos_x = ipx;
      req_pos_y = ipy;
      req_vel_x = ivx;
      req_vel_y = ivy;
      req_body_mass = im;
      req_valid = 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
      if (cmd == CMD_WRITE) loaded[a] = 1'b1;
      if (calm_items > 0) begin
         calm_items--;
         return;
      end
      if ($urandom_range(0, 99) == 0) calm_items = 30;
      else if ($urandom_range(0, 2) != 0) begin
         g = gap_len();
         req_valid = 1'b0;
         repeat (g) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      csr_index = idx;
      csr_wdata = val;
      csr_valid = 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [31:0] rand_word(int scale);
      case (scale)
         0: return $urandom();
         1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
         default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      endcase
   endfunction

   function automatic logic [7:0] pick_loaded();
      logic [7:0] i;
      do i = $urandom_range(0, 255); while (!loaded[i]);
      return i;
   endfunction

   task automatic random_item();
      int          r, sc;
      logic [31:0] m;
      logic [7:0]  a, b;
      r = $urandom_range(0, 99);
      sc = $urandom_range(0, 2);
      m = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 32'h0010_0000) :
          (($urandom() | 32'h1) ^ ($urandom_range(0, 1) ? 32'h0 : 32'h1));
      if (m == 0) m = 1;
      if (r < 25) begin
         send(CMD_WRITE, $urandom_range(0, 255), $urandom_range(0, 255), rand_word(sc),
              rand_word(sc), rand_word($urandom_range(0, 2)), rand_word(2), m);
      end else begin
         a = pick_loaded();
         b = pick_loaded();
         send(r < 60 ? CMD_INTERACT : (r < 80 ? CMD_UPDATE : CMD_READ), a, b,
              $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_READ;
      req_index_a = '0;
      req_index_b = '0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_vel_x = '0;
      req_vel_y = '0;
      req_body_mass = '0;
      csr_valid = 1'b0;
      csr_index = CSR_GRAV_DIVISOR;
      csr_wdata = '0;
      loaded = '0;
      long_hold = 0;
      idle_cycles = 0;
      calm_items = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send(CMD_WRITE, 0, 0, 0, 0, 0, 0, 32'h0001_0000);
      send(CMD_WRITE, 1, 0, 32'h000A_0000, 0, 0, 0, 32'h0001_0000);
      send(CMD_WRITE, 2, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
           32'hFFFF_FFFF);
      send(CMD_WRITE, 3, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
           32'h1);
      // zero mass body
      send(CMD_WRITE, 4, 0, 32'h0001_0000, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_8000, 0);
      send(CMD_WRITE, 255, 0, 32'h0003_0000, 0, 0, 0, 32'hFFFF_0000);
      send(CMD_INTERACT, 0, 1, 0, 0, 0, 0, 0);
      send(CMD_INTERACT, 1, 0, 0, 0, 0, 0, 0);
      send(CMD_INTERACT, 2, 3, 0, 0, 0, 0, 0);
      send(CMD_INTERACT, 0, 0, 0, 0, 0, 0, 0);
      send(CMD_INTERACT, 0, 255, 0, 0, 0, 0, 0);
      send(CMD_INTERACT, 4, 2, 0, 0, 0, 0, 0);
      send(CMD_INTERACT, 4, 0, 0, 0, 0, 0, 0);
      send(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 0);
      send(CMD_UPDATE, 1, 0, 0, 0, 0, 0, 0);
      send(CMD_UPDATE, 2, 0, 0, 0, 0, 0, 0);
      send(CMD_UPDATE, 3, 0, 0, 0, 0, 0, 0);
      send(CMD_UPDATE, 4, 0, 0, 0, 0, 0, 0);
      send(CMD_INTERACT, 3, 2, 0, 0, 0, 0, 0);
      send(CMD_UPDATE, 3, 0, 0, 0, 0, 0, 0);
      send(CMD_UPDATE, 2, 0, 0, 0, 0, 0, 0);
      send(CMD_READ, 255, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
           32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(CMD_READ, 4, 0, 0, 0, 0, 0, 0);

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         case (ph)
            1: begin
               csr_write(CSR_GRAV_DIVISOR, 32'd1);
               csr_write(CSR_TIME_STEP, 32'hFFFF_FFFF);
               csr_write(CSR_MIN_DISTANCE, 32'd0);
            end
            2: begin
               csr_write(CSR_GRAV_DIVISOR, 32'hFFFF_FFFF);
               csr_write(CSR_TIME_STEP, 32'd0);
               csr_write(CSR_MIN_DISTANCE, 32'hFFFF_FFFF);
            end
            3: begin
               csr_write(CSR_GRAV_DIVISOR, 32'h0001_0000);
               csr_write(CSR_TIME_STEP, 32'h0000_8000);
               csr_write(CSR_MIN_DISTANCE, 32'h0001_0000);
            end
            4: begin
               csr_write(CSR_GRAV_DIVISOR, $urandom_range(1, 32'hFFFF_FFFF));
               csr_write(CSR_TIME_STEP, $urandom());
               csr_write(CSR_MIN_DISTANCE, $urandom_range(0, 32'h0100_0000));
            end
            5: begin
               // zero divisor counts as one
               csr_write(CSR_GRAV_DIVISOR, 32'd0);
               csr_write(CSR_TIME_STEP, $urandom_range(0, 32'h0004_0000));
               csr_write(CSR_MIN_DISTANCE, $urandom_range(0, 32'h0008_0000));
            end
            default: ;
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 3 && n == 100) long_hold = 1;
            if (ph == 2 && n == 50) drain();
            random_item();
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (!sb.failed && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/pgi_pkg.sv
rtl/core/pairwise_gravity_integrator.sv
tb/pairwise_gravity_integrator_tb.sv
